[rtl/gidc_pkg.sv]
// Shared types and constants for the gamepad input event detector.
// Depends on nothing; every other rtl file refers to it by scoped names.
package gidc_pkg;

	localparam int NUM_BUTTONS = 12;
	localparam int NUM_LEVELS  = 14;
	localparam int NUM_SRC     = 16;
	localparam int NUM_LANES   = 6;
	localparam int RAW_W       = 16;
	localparam int SPAN_W      = RAW_W + 1;
	localparam int SCL_W       = RAW_W + 3;
	localparam int MAG_W       = SCL_W - 1;
	localparam int PROD_W      = SCL_W + 8;
	localparam int LIM_W       = 25;
	localparam int THR_W       = 7;
	localparam int SRC_W       = 4;
	localparam int LVL_W       = 3;
	localparam int CFG_IDX_W   = 2;

	// lane order
	localparam int LANE_LX = 0;
	localparam int LANE_LY = 1;
	localparam int LANE_RX = 2;
	localparam int LANE_RY = 3;
	localparam int LANE_LT = 4;
	localparam int LANE_RT = 5;

	// event sources beyond the buttons
	localparam logic [SRC_W-1:0] SRC_RIGHT_STICK = 4'd12;
	localparam logic [SRC_W-1:0] SRC_LEFT_STICK  = 4'd13;
	localparam logic [SRC_W-1:0] SRC_L2          = 4'd14;
	localparam logic [SRC_W-1:0] SRC_R2          = 4'd15;

	// level bits for the triggers inside the level vector
	localparam int LVL_L2 = 12;
	localparam int LVL_R2 = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

	typedef enum logic [LVL_W-1:0] {
		DIR_CENTER = 3'd0,
		DIR_UP     = 3'd1,
		DIR_DOWN   = 3'd2,
		DIR_LEFT   = 3'd3,
		DIR_RIGHT  = 3'd4
	} dir_t;

	// what one axis lane found about its axis
	typedef struct packed {
		logic             pos;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} lane_flags_t;

	// changes of one snapshot, handed from the merge stage to the drain
	typedef struct packed {
		logic [NUM_SRC-1:0]    mask;
		logic [NUM_LEVELS-1:0] btn;
		dir_t                  dir_r;
		dir_t                  dir_l;
	} evt_t;

endpackage

[rtl/gidc_axis_lane.sv]
// One axis lane: centres and scales a raw axis, then compares it against the threshold.
// Depends on gidc_pkg.
module gidc_axis_lane (
	input  logic                                      clk,
	input  logic                                      adv_s1,
	input  logic                                      adv_s2,
	input  logic signed [gidc_pkg::RAW_W-1:0]         raw,
	input  logic signed [gidc_pkg::RAW_W-1:0]         lo_bound,
	input  logic signed [gidc_pkg::SPAN_W-1:0]        span,
	input  logic signed [gidc_pkg::LIM_W-1:0]         lim,
	output gidc_pkg::lane_flags_t                     flags
);

	logic signed [gidc_pkg::SPAN_W-1:0] diff;
	logic signed [gidc_pkg::SCL_W-1:0]  n_d;
	logic signed [gidc_pkg::SCL_W-1:0]  n_s1;
	logic signed [gidc_pkg::PROD_W-1:0] nx;
	logic signed [gidc_pkg::PROD_W-1:0] p100;
	logic signed [gidc_pkg::PROD_W-1:0] limx;
	logic signed [gidc_pkg::SCL_W-1:0]  n_abs;
	gidc_pkg::lane_flags_t              flags_d;
	gidc_pkg::lane_flags_t              flags_s2;

	// n = 2*(raw - min) - span, so the normalised value is n / span
	assign diff = $signed({raw[gidc_pkg::RAW_W-1], raw})
		- $signed({lo_bound[gidc_pkg::RAW_W-1], lo_bound});
	assign n_d = $signed({diff[gidc_pkg::SPAN_W-1], diff, 1'b0})
		- $signed({{2{span[gidc_pkg::SPAN_W-1]}}, span});

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			n_s1 <= n_d;
		end
	end

	// 100*n by shift and add, against t*span
	assign nx    = $signed({{8{n_s1[gidc_pkg::SCL_W-1]}}, n_s1});
	assign p100  = (nx <<< 6) + (nx <<< 5) + (nx <<< 2);
	assign limx  = $signed({{(gidc_pkg::PROD_W - gidc_pkg::LIM_W){lim[gidc_pkg::LIM_W-1]}}, lim});
	assign n_abs = n_s1[gidc_pkg::SCL_W-1] ? -n_s1 : n_s1;

	always_comb begin
		flags_d.pos = p100 > limx;
		flags_d.neg = p100 < -limx;
		flags_d.mag = n_abs[gidc_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			flags_s2 <= flags_d;
		end
	end

	assign flags = flags_s2;

endmodule

[rtl/gidc_merge.sv]
// Merge stage: combines the lane results into directions and levels and holds the kept state.
// Depends on gidc_pkg.
module gidc_merge (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              fire,
	input  logic                                              span_ok,
	input  logic [gidc_pkg::NUM_BUTTONS-1:0]                  buttons,
	input  gidc_pkg::lane_flags_t [gidc_pkg::NUM_LANES-1:0]   lanes,
	output gidc_pkg::evt_t                                    evt
);

	logic [gidc_pkg::NUM_LEVELS-1:0] lvl_q;
	gidc_pkg::dir_t                  dir_r_q;
	gidc_pkg::dir_t                  dir_l_q;
	logic [gidc_pkg::NUM_LEVELS-1:0] lvl_d;
	gidc_pkg::dir_t                  dir_r_d;
	gidc_pkg::dir_t                  dir_l_d;

	function automatic gidc_pkg::dir_t stick_dir(
		input gidc_pkg::lane_flags_t x,
		input gidc_pkg::lane_flags_t y,
		input logic                  ok
	);
		gidc_pkg::dir_t d;
		d = gidc_pkg::DIR_CENTER;
		if (ok) begin
			if (x.mag > y.mag) begin
				if (x.pos)      d = gidc_pkg::DIR_RIGHT;
				else if (x.neg) d = gidc_pkg::DIR_LEFT;
			end else begin
				if (y.pos)      d = gidc_pkg::DIR_UP;
				else if (y.neg) d = gidc_pkg::DIR_DOWN;
			end
		end
		return d;
	endfunction

	always_comb begin
		dir_r_d = stick_dir(lanes[gidc_pkg::LANE_RX], lanes[gidc_pkg::LANE_RY], span_ok);
		dir_l_d = stick_dir(lanes[gidc_pkg::LANE_LX], lanes[gidc_pkg::LANE_LY], span_ok);
		lvl_d   = {lanes[gidc_pkg::LANE_RT].pos & span_ok,
			lanes[gidc_pkg::LANE_LT].pos & span_ok, buttons};

		evt.mask[gidc_pkg::NUM_BUTTONS-1:0] = lvl_d[gidc_pkg::NUM_BUTTONS-1:0]
			^ lvl_q[gidc_pkg::NUM_BUTTONS-1:0];
		evt.mask[gidc_pkg::SRC_RIGHT_STICK] = dir_r_d != dir_r_q;
		evt.mask[gidc_pkg::SRC_LEFT_STICK]  = dir_l_d != dir_l_q;
		evt.mask[gidc_pkg::SRC_L2] = lvl_d[gidc_pkg::LVL_L2] ^ lvl_q[gidc_pkg::LVL_L2];
		evt.mask[gidc_pkg::SRC_R2] = lvl_d[gidc_pkg::LVL_R2] ^ lvl_q[gidc_pkg::LVL_R2];
		evt.btn   = lvl_d;
		evt.dir_r = dir_r_d;
		evt.dir_l = dir_l_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			dir_r_q <= gidc_pkg::DIR_CENTER;
			dir_l_q <= gidc_pkg::DIR_CENTER;
		end else if (fire) begin
			lvl_q   <= lvl_d;
			dir_r_q <= dir_r_d;
			dir_l_q <= dir_l_d;
		end
	end

endmodule

[rtl/gidc_drain.sv]
// Event drain: holds the change set of one snapshot and issues its events one per cycle while out_ready allows.
// Depends on gidc_pkg.
module gidc_drain (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  gidc_pkg::evt_t                   evt,
	output logic                             load_ok,
	output logic                             busy,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gidc_pkg::SRC_W-1:0]       source,
	output logic [gidc_pkg::LVL_W-1:0]       new_level,
	output logic                             last
);

	logic [gidc_pkg::NUM_SRC-1:0]    mask_q;
	logic [gidc_pkg::NUM_LEVELS-1:0] btn_q;
	gidc_pkg::dir_t                  dir_r_q;
	gidc_pkg::dir_t                  dir_l_q;
	logic                            valid_q;
	logic [gidc_pkg::SRC_W-1:0]      source_q;
	logic [gidc_pkg::LVL_W-1:0]      level_q;
	logic                            last_q;
	logic [gidc_pkg::NUM_SRC-1:0]    mask_rest;
	logic [gidc_pkg::SRC_W-1:0]      k;
	logic [gidc_pkg::LVL_W-1:0]      lvl_k;
	logic                            step;

	// lowest pending source goes first
	always_comb begin
		k = '0;
		for (int i = gidc_pkg::NUM_SRC - 1; i >= 0; i--) begin
			if (mask_q[i]) k = gidc_pkg::SRC_W'(i);
		end
	end

	always_comb begin
		case (k)
			gidc_pkg::SRC_RIGHT_STICK: lvl_k = dir_r_q;
			gidc_pkg::SRC_LEFT_STICK:  lvl_k = dir_l_q;
			gidc_pkg::SRC_L2:          lvl_k = {2'b00, btn_q[gidc_pkg::LVL_L2]};
			gidc_pkg::SRC_R2:          lvl_k = {2'b00, btn_q[gidc_pkg::LVL_R2]};
			default:                   lvl_k = {2'b00, btn_q[k]};
		endcase
	end

	assign mask_rest = mask_q & (mask_q - 1'b1);
	assign busy      = mask_q != '0;
	assign step      = busy && (!valid_q || out_ready);
	assign load_ok   = !busy || (step && mask_rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= evt.mask;
		end else if (step) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			btn_q   <= evt.btn;
			dir_r_q <= evt.dir_r;
			dir_l_q <= evt.dir_l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			source_q <= k;
			level_q  <= lvl_k;
			last_q   <= mask_rest == '0;
		end
	end

	assign out_valid = valid_q;
	assign source    = source_q;
	assign new_level = level_q;
	assign last      = last_q;

endmodule

[rtl/gamepad_input_event_detector_core.sv]
// Top level of the gamepad input event detector: configuration, pipeline control, lanes.
// Depends on gidc_pkg, gidc_axis_lane, gidc_merge and gidc_drain.
//
// Each snapshot transfer carries 12 button bits and six raw signed axes. Six axis lanes
// work side by side: stage one centres each axis against the configured range, stage two
// scales it by 100 and compares it with threshold_percent times the span, so no division
// is needed. The merge stage then picks each stick's dominant axis, forms the trigger
// levels, compares everything with the kept levels and directions and updates them. Every
// change becomes one event, in the order buttons 0 to 11, right stick, left stick, L2, R2;
// the final event of a snapshot carries last. A snapshot that changes nothing gives no
// event. While enable is 0 snapshots are taken and dropped. If the upper end of the range
// is not above the lower end, sticks read as centred and triggers as released.
// Rate: a snapshot can be taken every cycle while in_ready is high; its events pass the
// stage one, stage two, drain and output registers. The drain issues one event per cycle
// while out_ready allows, at most 16 per snapshot, and a snapshot with changes waits in
// the merge stage until the drain can take its change set. The output register and the
// stage registers let a new snapshot be taken while earlier events still wait on out_ready.
// Configuration: write only while no snapshot is in flight; cfg_ready is always high.
module gamepad_input_event_detector_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [gidc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gidc_pkg::RAW_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [gidc_pkg::NUM_BUTTONS-1:0]       buttons,
	input  logic signed [gidc_pkg::RAW_W-1:0]      left_x,
	input  logic signed [gidc_pkg::RAW_W-1:0]      left_y,
	input  logic signed [gidc_pkg::RAW_W-1:0]      right_x,
	input  logic signed [gidc_pkg::RAW_W-1:0]      right_y,
	input  logic signed [gidc_pkg::RAW_W-1:0]      left_trigger,
	input  logic signed [gidc_pkg::RAW_W-1:0]      right_trigger,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [gidc_pkg::SRC_W-1:0]             source,
	output logic [gidc_pkg::LVL_W-1:0]             new_level,
	output logic                                   last
);

	// configuration registers
	logic                               enable_q;
	logic signed [gidc_pkg::RAW_W-1:0]  rng_lo_q;
	logic signed [gidc_pkg::RAW_W-1:0]  rng_hi_q;
	logic [gidc_pkg::THR_W-1:0]         thr_q;

	// pipeline control and side payload
	logic                               valid_s1;
	logic                               valid_s2;
	logic                               span_ok_s1;
	logic                               span_ok_s2;
	logic [gidc_pkg::NUM_BUTTONS-1:0]   btn_s1;
	logic [gidc_pkg::NUM_BUTTONS-1:0]   btn_s2;
	logic signed [gidc_pkg::LIM_W-1:0]  lim_s1;

	logic signed [gidc_pkg::SPAN_W-1:0] span;
	logic                               span_ok;
	logic signed [gidc_pkg::LIM_W-1:0]  lim_d;
	logic                               in_xfer;
	logic                               adv_s1;
	logic                               adv_s2;
	logic                               s2_free;
	logic                               merge_fire;
	logic                               drain_load;
	logic                               load_ok;
	logic                               drain_busy;

	logic signed [gidc_pkg::RAW_W-1:0]                   raw [gidc_pkg::NUM_LANES];
	gidc_pkg::lane_flags_t [gidc_pkg::NUM_LANES-1:0]     lane_flags;
	gidc_pkg::evt_t                                      evt;

	// --- configuration port: never stalls ---
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rng_lo_q <= '0;
			rng_hi_q <= 16'sd255;
			thr_q    <= 7'd30;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gidc_pkg::CFG_ENABLE:    enable_q <= cfg_data[0];
				gidc_pkg::CFG_RANGE_MIN: rng_lo_q <= cfg_data;
				gidc_pkg::CFG_RANGE_MAX: rng_hi_q <= cfg_data;
				gidc_pkg::CFG_THRESHOLD: thr_q    <= cfg_data[gidc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// span and threshold limit, shared by every lane
	assign span = $signed({rng_hi_q[gidc_pkg::RAW_W-1], rng_hi_q})
		- $signed({rng_lo_q[gidc_pkg::RAW_W-1], rng_lo_q});
	assign span_ok = !span[gidc_pkg::SPAN_W-1] && (span != '0);
	assign lim_d = $signed({{(gidc_pkg::LIM_W - gidc_pkg::THR_W){1'b0}}, thr_q})
		* $signed({{(gidc_pkg::LIM_W - gidc_pkg::SPAN_W){span[gidc_pkg::SPAN_W-1]}}, span});

	// --- pipeline control: advance a stage when the next one is free or leaving ---
	assign merge_fire = valid_s2 && ((evt.mask == '0) || load_ok);
	assign drain_load = merge_fire && (evt.mask != '0);
	assign s2_free    = !valid_s2 || merge_fire;
	assign adv_s2     = valid_s1 && s2_free;
	assign in_ready   = !valid_s1 || adv_s2;
	assign in_xfer    = in_valid && in_ready;
	assign adv_s1     = in_xfer && enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			// a disabled snapshot is taken and dropped here
			if (in_xfer)     valid_s1 <= enable_q;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2)          valid_s2 <= 1'b1;
			else if (merge_fire) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			btn_s1     <= buttons;
			span_ok_s1 <= span_ok;
			lim_s1     <= lim_d;
		end
		if (adv_s2) begin
			btn_s2     <= btn_s1;
			span_ok_s2 <= span_ok_s1;
		end
	end

	// --- axis lanes ---
	assign raw[gidc_pkg::LANE_LX] = left_x;
	assign raw[gidc_pkg::LANE_LY] = left_y;
	assign raw[gidc_pkg::LANE_RX] = right_x;
	assign raw[gidc_pkg::LANE_RY] = right_y;
	assign raw[gidc_pkg::LANE_LT] = left_trigger;
	assign raw[gidc_pkg::LANE_RT] = right_trigger;

	for (genvar g = 0; g < gidc_pkg::NUM_LANES; g++) begin : g_lane
		gidc_axis_lane u_lane (
			.clk      (clk),
			.adv_s1   (adv_s1),
			.adv_s2   (adv_s2),
			.raw      (raw[g]),
			.lo_bound (rng_lo_q),
			.span     (span),
			.lim      (lim_s1),
			.flags    (lane_flags[g])
		);
	end

	// --- merge: directions, levels, change set, kept state ---
	gidc_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (merge_fire),
		.span_ok (span_ok_s2),
		.buttons (btn_s2),
		.lanes   (lane_flags),
		.evt     (evt)
	);

	// --- drain: one event per transfer ---
	gidc_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (drain_load),
		.evt       (evt),
		.load_ok   (load_ok),
		.busy      (drain_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.source    (source),
		.new_level (new_level),
		.last      (last)
	);

`ifndef ASSERT_OFF
	// a change set handed to the drain must show up as pending or issued work
	a_load_seen: assert property (@(posedge clk) disable iff (!arst_n)
		drain_load |=> (drain_busy || out_valid))
		else $error("change set lost on its way into the drain");

	// a blocked merge stage with a full first stage must hold off the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !merge_fire) |-> !in_ready)
		else $error("input taken while the pipeline is full");

	// a snapshot taken while disabled must not enter the pipeline
	a_disabled_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !enable_q) |=> !valid_s1)
		else $error("disabled snapshot entered the pipeline");

	// the drain is loaded only when its previous set has run out
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		drain_load |-> load_ok)
		else $error("drain loaded over pending events");
`endif

endmodule
